FILE: design/rfsw_pkg.sv
// Package: width constants, register reset values and the register index type.
package rfsw_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int THR_BITS      = 31;
   localparam int GRAV_BITS     = 22;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [THR_BITS-1:0]  DRY_THRESHOLD_RST = THR_BITS'(1);
   localparam logic [GRAV_BITS-1:0] GRAVITY_RST       = GRAV_BITS'(642908);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DRY_THRESHOLD = 1'b0,
      CSR_GRAVITY       = 1'b1
   } csr_idx_type;

endpackage

FILE: design/rfsw_if.sv
// Interfaces: valid/ready channels for edge requests, flux responses and register writes.
interface rfsw_req_if;
   logic        valid;
   logic        ready;
   logic [30:0] h_left;
   logic [31:0] u_left;
   logic [31:0] v_left;
   logic [30:0] h_right;
   logic [31:0] u_right;
   logic [31:0] v_right;
   modport source (output valid, h_left, u_left, v_left, h_right, u_right, v_right,
                   input ready);
   modport sink   (input valid, h_left, u_left, v_left, h_right, u_right, v_right,
                   output ready);
endinterface

interface rfsw_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] flux_mass;
   logic [31:0] flux_normal_momentum;
   logic [31:0] flux_tangent_momentum;
   logic [30:0] max_wave_speed;
   modport source (output valid, flux_mass, flux_normal_momentum, flux_tangent_momentum,
                   max_wave_speed, input ready);
   modport sink   (input valid, flux_mass, flux_normal_momentum, flux_tangent_momentum,
                   max_wave_speed, output ready);
endinterface

interface rfsw_csr_if;
   logic        valid;
   logic        ready;
   logic [rfsw_pkg::CSR_IDX_BITS-1:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/rfsw_mul.sv
// Saturating fixed-point multiplier: magnitude product, truncate, clamp, sign, one register stage.
module rfsw_mul #(
   parameter int W = rfsw_pkg::WORD_BITS_DEF,
   parameter int F = rfsw_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [W-1:0] a,
   input  logic signed [W-1:0] b,
   output logic signed [W-1:0] p
);
   logic [W-1:0]   ma, mb;
   logic [2*W-1:0] prod, sh;
   logic [W:0]     lim;
   logic           neg;
   logic [W:0]     m;
   logic signed [W-1:0] p_in, p_ff;

   always_comb begin
      neg  = a[W-1] ^ b[W-1];
      ma   = a[W-1] ? (~a + W'(1)) : a;
      mb   = b[W-1] ? (~b + W'(1)) : b;
      prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
      sh   = prod >> F;
      lim  = neg ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - (W+1)'(1));
      if (sh > {{(W-1){1'b0}}, lim}) begin
         m = lim;
      end else begin
         m = sh[W:0];
      end
      p_in = neg ? W'(~m + (W+1)'(1)) : W'(m);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;
endmodule

FILE: design/rusanov_flux_shallow_water.sv
// Rusanov flux for 2D shallow water: pipelined, one edge per cycle unless the response stalls.
// Throughput: one edge beat per cycle unless the response stalls; the square-root
// stages (four root bits per stage, eight stages) bound the pipeline depth, not the rate.
// Reset: synchronous active-high reset clears all valid bits and restores
// dry_threshold = 1 LSB and gravity = 9.81 in Q16.16.
module rusanov_flux_shallow_water #(
   parameter int WORD_BITS = rfsw_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = rfsw_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   rfsw_req_if.sink   req,
   rfsw_rsp_if.source rsp,
   rfsw_csr_if.sink   csr
);
   localparam int W  = WORD_BITS;
   localparam int NS = 14;
   localparam int RB = (W + FRAC_BITS + 1) / 2 + 1;  // root bits needed
   localparam int SQ = 8;                             // sqrt stages
   localparam int BPS = (RB + SQ - 1) / SQ;
   localparam int RT = BPS * SQ;                      // root bits processed
   localparam int RW = 2 * RT;                        // radicand width

   typedef logic signed [W-1:0] w_type;

   localparam w_type WMAX = w_type'({1'b0, {(W-1){1'b1}}});
   localparam w_type WMIN = w_type'({1'b1, {(W-1){1'b0}}});

   function automatic w_type sadd(w_type a, w_type b);
      logic signed [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
      return s[W-1:0];
   endfunction

   function automatic w_type ssub(w_type a, w_type b);
      logic signed [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
      return s[W-1:0];
   endfunction

   function automatic w_type sabs(w_type a);
      if (a == WMIN) return WMAX;
      return a[W-1] ? -a : a;
   endfunction

   function automatic w_type half(w_type a);
      w_type t;
      t = a + ((a[W-1]) ? w_type'(1) : w_type'(0));
      return t >>> 1;
   endfunction

   function automatic w_type from_u31(logic [30:0] x);
      if (W >= 32) return w_type'({{(W > 31 ? W-31 : 1){1'b0}}, x});
      if (x > 31'(WMAX)) return WMAX;
      return w_type'(x);
   endfunction

   function automatic w_type from_s32(logic [31:0] x);
      logic signed [63:0] e;
      e = 64'(signed'(x));
      if (W >= 32) return w_type'(e);
      if (e > 64'(WMAX)) return WMAX;
      if (e < 64'(WMIN)) return WMIN;
      return w_type'(e);
   endfunction

   // ---------------- registers ----------------
   logic [rfsw_pkg::THR_BITS-1:0]  thr_ff;
   logic [rfsw_pkg::GRAV_BITS-1:0] grav_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= rfsw_pkg::DRY_THRESHOLD_RST;
         grav_ff <= rfsw_pkg::GRAVITY_RST;
      end else if (csr.valid) begin
         case (rfsw_pkg::csr_idx_type'(csr.index))
            rfsw_pkg::CSR_DRY_THRESHOLD: thr_ff  <= csr.data[rfsw_pkg::THR_BITS-1:0];
            rfsw_pkg::CSR_GRAVITY:       grav_ff <= csr.data[rfsw_pkg::GRAV_BITS-1:0];
            default: ;
         endcase
      end
   end
   assign csr.ready = 1'b1;

   // ---------------- pipeline control ----------------
   logic [NS-1:0] vld_ff;
   logic          adv;
   assign adv       = !vld_ff[NS-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req.valid};
      end
   end

   w_type g_w, gd_w;
   assign g_w  = from_u31(31'(grav_ff));
   assign gd_w = from_u31(31'(grav_ff >> 1));

   // stage 0: capture inputs
   w_type hl0_ff, ul0_ff, vl0_ff, hr0_ff, ur0_ff, vr0_ff;
   logic  dry0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         hl0_ff  <= from_u31(req.h_left);
         ul0_ff  <= from_s32(req.u_left);
         vl0_ff  <= from_s32(req.v_left);
         hr0_ff  <= from_u31(req.h_right);
         ur0_ff  <= from_s32(req.u_right);
         vr0_ff  <= from_s32(req.v_right);
         dry0_ff <= (req.h_left < thr_ff) && (req.h_right < thr_ff);
      end
   end

   // stage 1: first multiplies
   w_type ghl1, ghr1, ql1, qr1, gdl1, gdr1, hvl1, hvr1;
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_m0 (.clock, .en(adv), .a(g_w),    .b(hl0_ff), .p(ghl1));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_m1 (.clock, .en(adv), .a(g_w),    .b(hr0_ff), .p(ghr1));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_m2 (.clock, .en(adv), .a(ul0_ff), .b(hl0_ff), .p(ql1));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_m3 (.clock, .en(adv), .a(ur0_ff), .b(hr0_ff), .p(qr1));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_m4 (.clock, .en(adv), .a(gd_w),   .b(hl0_ff), .p(gdl1));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_m5 (.clock, .en(adv), .a(gd_w),   .b(hr0_ff), .p(gdr1));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_m6 (.clock, .en(adv), .a(hl0_ff), .b(vl0_ff), .p(hvl1));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_m7 (.clock, .en(adv), .a(hr0_ff), .b(vr0_ff), .p(hvr1));

   w_type hl1_ff, ul1_ff, vl1_ff, hr1_ff, ur1_ff, vr1_ff;
   logic  dry1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         hl1_ff <= hl0_ff; ul1_ff <= ul0_ff; vl1_ff <= vl0_ff;
         hr1_ff <= hr0_ff; ur1_ff <= ur0_ff; vr1_ff <= vr0_ff;
         dry1_ff <= dry0_ff;
      end
   end

   // stage 2: second multiplies
   w_type pl2, pr2, gl2, gr2, tl2, tr2;
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_n0 (.clock, .en(adv), .a(ul1_ff), .b(ql1), .p(pl2));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_n1 (.clock, .en(adv), .a(ur1_ff), .b(qr1), .p(pr2));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_n2 (.clock, .en(adv), .a(gdl1),   .b(hl1_ff), .p(gl2));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_n3 (.clock, .en(adv), .a(gdr1),   .b(hr1_ff), .p(gr2));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_n4 (.clock, .en(adv), .a(ql1),    .b(vl1_ff), .p(tl2));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_n5 (.clock, .en(adv), .a(qr1),    .b(vr1_ff), .p(tr2));

   w_type ql2_ff, qr2_ff, hl2_ff, hr2_ff, hvl2_ff, hvr2_ff, aul2_ff, aur2_ff;
   logic [RW-1:0] rl2_ff, rr2_ff;
   logic  dry2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ql2_ff <= ql1; qr2_ff <= qr1; hl2_ff <= hl1_ff; hr2_ff <= hr1_ff;
         hvl2_ff <= hvl1; hvr2_ff <= hvr1;
         aul2_ff <= sabs(ul1_ff); aur2_ff <= sabs(ur1_ff);
         rl2_ff <= ghl1[W-1] ? '0 : (RW'(ghl1) << FRAC_BITS);
         rr2_ff <= ghr1[W-1] ? '0 : (RW'(ghr1) << FRAC_BITS);
         dry2_ff <= dry1_ff;
      end
   end

   // stage 3: partial sums and differences
   w_type s13_ff, sum3_ff, t3_ff, dh3_ff, dq3_ff, dhv3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s13_ff  <= half(sadd(ql2_ff, qr2_ff));
         sum3_ff <= sadd(sadd(sadd(pl2, gl2), pr2), gr2);
         t3_ff   <= half(sadd(tl2, tr2));
         dh3_ff  <= ssub(hr2_ff, hl2_ff);
         dq3_ff  <= ssub(qr2_ff, ql2_ff);
         dhv3_ff <= ssub(hvr2_ff, hvl2_ff);
      end
   end

   // stages 3..10: square roots, BPS root bits per stage
   typedef struct packed {
      logic [RW-1:0] rad;
      logic [RT+1:0] rem;
      logic [RT-1:0] root;
   } sq_type;

   function automatic sq_type sq_step(sq_type s);
      sq_type o;
      logic [RT+1:0] trial;
      o = s;
      for (int k = 0; k < BPS; k++) begin
         o.rem = {o.rem[RT-1:0], o.rad[RW-1:RW-2]};
         o.rad = o.rad << 2;
         trial = {o.root, 2'b01};
         if (o.rem >= trial) begin
            o.rem  = o.rem - trial;
            o.root = {o.root[RT-2:0], 1'b1};
         end else begin
            o.root = {o.root[RT-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   sq_type sql_ff [SQ];
   sq_type sqr_ff [SQ];
   w_type  aul_ff [SQ];
   w_type  aur_ff [SQ];
   always_ff @(posedge clock) begin
      if (adv) begin
         sql_ff[0] <= sq_step('{rad: rl2_ff, rem: '0, root: '0});
         sqr_ff[0] <= sq_step('{rad: rr2_ff, rem: '0, root: '0});
         aul_ff[0] <= aul2_ff;
         aur_ff[0] <= aur2_ff;
         for (int i = 1; i < SQ; i++) begin
            sql_ff[i] <= sq_step(sql_ff[i-1]);
            sqr_ff[i] <= sq_step(sqr_ff[i-1]);
            aul_ff[i] <= aul_ff[i-1];
            aur_ff[i] <= aur_ff[i-1];
         end
      end
   end

   // carry the flux terms alongside the root
   typedef struct packed {
      w_type s1, sum, t, dh, dq, dhv;
      logic  dry;
   } fl_type;
   fl_type fl_ff [SQ-1];
   logic   dry3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dry3_ff <= dry2_ff;
         fl_ff[0] <= '{s1: s13_ff, sum: sum3_ff, t: t3_ff, dh: dh3_ff, dq: dq3_ff,
                       dhv: dhv3_ff, dry: dry3_ff};
         for (int i = 1; i < SQ-1; i++) begin
            fl_ff[i] <= fl_ff[i-1];
         end
      end
   end

   // stage 11: wave speed
   w_type sql_w, sqr_w, cl, cr, c11_ff;
   fl_type fl11_ff;
   assign sql_w = (sql_ff[SQ-1].root > RT'(WMAX)) ? WMAX : w_type'(sql_ff[SQ-1].root);
   assign sqr_w = (sqr_ff[SQ-1].root > RT'(WMAX)) ? WMAX : w_type'(sqr_ff[SQ-1].root);
   assign cl = sadd(aul_ff[SQ-1], sql_w);
   assign cr = sadd(aur_ff[SQ-1], sqr_w);
   always_ff @(posedge clock) begin
      if (adv) begin
         c11_ff  <= (cl > cr) ? cl : cr;
         fl11_ff <= fl_ff[SQ-2];
      end
   end

   // stage 12: diffusion products
   w_type cd;
   w_type d1, d2, d3;
   assign cd = half(c11_ff);
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_d0 (.clock, .en(adv), .a(cd), .b(fl11_ff.dh),  .p(d1));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_d1 (.clock, .en(adv), .a(cd), .b(fl11_ff.dq),  .p(d2));
   rfsw_mul #(.W(W), .F(FRAC_BITS)) u_d2 (.clock, .en(adv), .a(cd), .b(fl11_ff.dhv), .p(d3));
   w_type  c12_ff;
   fl_type fl12_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         c12_ff  <= c11_ff;
         fl12_ff <= fl11_ff;
      end
   end

   // stage 13: output register
   w_type f1_ff, f2_ff, f3_ff, c13_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         if (fl12_ff.dry) begin
            f1_ff <= '0; f2_ff <= '0; f3_ff <= '0; c13_ff <= '0;
         end else begin
            f1_ff  <= ssub(fl12_ff.s1, d1);
            f2_ff  <= ssub(half(fl12_ff.sum), d2);
            f3_ff  <= ssub(fl12_ff.t, d3);
            c13_ff <= c12_ff;
         end
      end
   end

   assign rsp.valid                 = vld_ff[NS-1];
   assign rsp.flux_mass             = 32'(f1_ff);
   assign rsp.flux_normal_momentum  = 32'(f2_ff);
   assign rsp.flux_tangent_momentum = 32'(f3_ff);
   assign rsp.max_wave_speed        = 31'(c13_ff);
endmodule
